// File: hdl/ppsm_pkg.sv
`default_nettype none

package ppsm_pkg;

	// Field widths
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned PITCH_W = 10;
	localparam int unsigned SPEED_W = 27;

	// Speed scale: mm/us -> cm/s
	localparam logic [16:0] SPEED_SCALE = 17'd100000;

	// Smoothed interval when no interval is stored
	localparam logic [TIME_W-1:0] NO_INTERVAL = '1;

	// Pitch after reset
	localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(10);

	// Action codes
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	// Commands to the interval ring
	typedef struct packed {
		logic clear;
		logic push;
		logic rd_en;
	} ring_cmd_t;

endpackage

`default_nettype wire

// File: hdl/ppsm_if.sv
`default_nettype none

// Sample channel
interface ppsm_in_if;
	import ppsm_pkg::*;

	logic              valid;
	logic              ready;
	logic              action;
	logic              sensor_level;
	logic [TIME_W-1:0] now_us;

	modport source (output valid, action, sensor_level, now_us, input ready);
	modport sink   (input valid, action, sensor_level, now_us, output ready);
endinterface

// Result channel
interface ppsm_out_if;
	import ppsm_pkg::*;

	logic               valid;
	logic               ready;
	logic [SPEED_W-1:0] speed_cm_s;
	logic [TIME_W-1:0]  smoothed_interval_us;
	logic [TIME_W-1:0]  lines_counted;
	logic               edge_recorded;

	modport source (output valid, speed_cm_s, smoothed_interval_us, lines_counted,
		edge_recorded, input ready);
	modport sink   (input valid, speed_cm_s, smoothed_interval_us, lines_counted,
		edge_recorded, output ready);
endinterface

`default_nettype wire

// File: hdl/ppsm_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The numerator is MSB
// aligned by the caller; len sets how many of its top bits are consumed.
module ppsm_div #(
	parameter int unsigned NUM_W = 35,
	parameter int unsigned DEN_W = 32,
	parameter int unsigned LEN_W = 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	input  wire logic [LEN_W-1:0] len,
	output logic                  done,
	output logic [NUM_W-1:0]      quot
);

	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [LEN_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic             fits;

	// Shift in next numerator bit and try the subtract
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		fits  = (trial >= {1'b0, den_q});
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= len;
			end else if (busy_q) begin
				cnt_q <= cnt_q - LEN_W'(1);
				if (cnt_q == LEN_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			quot_q <= {quot_q[NUM_W-2:0], fits};
			rem_q  <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

// File: hdl/ppsm_ring.sv
`default_nettype none

// Ring of the most recent intervals: write pointer, saturating fill count
// and a one-port-read memory with registered read data.
module ppsm_ring #(
	parameter int unsigned WINDOW = 8,
	parameter int unsigned IDX_W  = 3,
	parameter int unsigned CNT_W  = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ppsm_pkg::ring_cmd_t           cmd,
	input  wire logic [ppsm_pkg::TIME_W-1:0]   wr_data,
	input  wire logic [IDX_W-1:0]              rd_addr,
	output logic [ppsm_pkg::TIME_W-1:0]        rd_data,
	output logic [CNT_W-1:0]                   fill
);
	import ppsm_pkg::*;

	logic [TIME_W-1:0] mem_q [WINDOW];
	logic [TIME_W-1:0] rd_data_q;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  fill_q;

	// Pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (cmd.clear) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (cmd.push) begin
			head_q <= (head_q == IDX_W'(WINDOW - 1)) ? '0 : head_q + IDX_W'(1);
			if (fill_q != CNT_W'(WINDOW)) begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end
	end

	// Memory write
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem_q[head_q] <= wr_data;
		end
	end

	// Memory read
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign fill    = fill_q;

endmodule

`default_nettype wire

// File: hdl/pulse_period_speed_meter.sv
`default_nettype none

// Channel     Dir  Payload
// sample_ch   in   action, sensor_level, now_us
// result_ch   out  speed_cm_s, smoothed_interval_us, lines_counted, edge_recorded
// cfg_we/data in   line spacing in mm, written while idle
//
// Each item runs from accept to the next ready as a read pass over the
// stored intervals, then two runs of the shared bit-serial divider (mean,
// then speed). Both runs are skipped with an empty ring; the speed run is
// skipped on a zero or all-ones effective interval. Reset empties the ring
// and sets the pitch to 10.
// A finished result waits in the output register; sample_ch is ready
// whenever the sequencer is idle, even while that result is stalled.
module pulse_period_speed_meter #(
	parameter int unsigned WINDOW = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ppsm_pkg::PITCH_W-1:0]   cfg_data,
	ppsm_in_if.sink                             sample_ch,
	ppsm_out_if.source                          result_ch
);
	import ppsm_pkg::*;

	localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned CNT_W = $clog2(WINDOW + 1);
	localparam int unsigned SUM_W = TIME_W + $clog2(WINDOW);
	localparam int unsigned LEN_W = $clog2(SUM_W + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_MEAN_DIV,
		ST_MEAN_WAIT,
		ST_EFF,
		ST_SPEED_WAIT,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [PITCH_W-1:0] pitch_q;
	logic               armed_q;
	logic [TIME_W-1:0]  last_edge_q;
	logic [TIME_W-1:0]  edge_total_q;
	logic [TIME_W-1:0]  now_q;
	logic               edge_q;
	logic [SPEED_W-1:0] prod_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               rd_vld_q;
	logic [TIME_W-1:0]  mean_q;
	logic [SPEED_W-1:0] speed_q;

	logic               out_vld_q;
	logic [SPEED_W-1:0] out_speed_q;
	logic [TIME_W-1:0]  out_mean_q;
	logic [TIME_W-1:0]  out_lines_q;
	logic               out_edge_q;

	ring_cmd_t          ring_cmd;
	logic [TIME_W-1:0]  ring_rd_data;
	logic [CNT_W-1:0]   ring_fill;
	logic [TIME_W-1:0]  interval;

	logic               accept;
	logic               is_edge;
	logic               sum_last;
	logic [TIME_W-1:0]  elapsed;
	logic [TIME_W-1:0]  eff;
	logic               eff_bad;

	logic               div_start;
	logic [SUM_W-1:0]   div_num;
	logic [TIME_W-1:0]  div_den;
	logic [LEN_W-1:0]   div_len;
	logic               div_done;
	logic [SUM_W-1:0]   div_quot;

	// Item decode
	always_comb begin
		accept   = (state_q == ST_IDLE) && sample_ch.valid;
		is_edge  = (sample_ch.action == ACT_SAMPLE) && sample_ch.sensor_level && !armed_q;
		interval = sample_ch.now_us - last_edge_q;
		sum_last = (cnt_q == ring_fill) && !rd_vld_q;
	end

	// Ring commands
	always_comb begin
		ring_cmd.clear = accept && (sample_ch.action == ACT_CLEAR);
		ring_cmd.push  = accept && is_edge;
		ring_cmd.rd_en = (state_q == ST_SUM) && (cnt_q != ring_fill);
	end

	// Effective interval: larger of mean and time since last edge
	always_comb begin
		elapsed = now_q - last_edge_q;
		eff     = (mean_q > elapsed) ? mean_q : elapsed;
		eff_bad = (eff == '0) || (eff == NO_INTERVAL);
	end

	// Divider operand select
	always_comb begin
		div_start = 1'b0;
		div_num   = sum_q;
		div_den   = TIME_W'(ring_fill);
		div_len   = LEN_W'(SUM_W);
		case (state_q)
			ST_MEAN_DIV: begin
				div_start = 1'b1;
			end
			ST_EFF: begin
				div_start = !eff_bad;
				div_num   = {prod_q, (SUM_W - SPEED_W)'(0)};
				div_den   = eff;
				div_len   = LEN_W'(SPEED_W);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= PITCH_RESET;
		end else if (cfg_we) begin
			pitch_q <= cfg_data;
		end
	end

	// Sequencer, tracking state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			armed_q      <= 1'b0;
			last_edge_q  <= '0;
			edge_total_q <= '0;
			rd_vld_q     <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			// output register: load a finished item, else drop on take
			if ((state_q == ST_DONE) && (!out_vld_q || result_ch.ready)) begin
				out_vld_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (sample_ch.action == ACT_SAMPLE) begin
							if (!sample_ch.sensor_level) begin
								armed_q <= 1'b0;
							end else if (!armed_q) begin
								armed_q      <= 1'b1;
								last_edge_q  <= sample_ch.now_us;
								edge_total_q <= edge_total_q + TIME_W'(1);
							end
						end
						rd_vld_q <= 1'b0;
						state_q  <= ST_SUM;
					end
				end
				ST_SUM: begin
					rd_vld_q <= ring_cmd.rd_en;
					if (sum_last) begin
						state_q <= (ring_fill == '0) ? ST_DONE : ST_MEAN_DIV;
					end
				end
				ST_MEAN_DIV: begin
					state_q <= ST_MEAN_WAIT;
				end
				ST_MEAN_WAIT: begin
					if (div_done) begin
						state_q <= ST_EFF;
					end
				end
				ST_EFF: begin
					state_q <= eff_bad ? ST_DONE : ST_SPEED_WAIT;
				end
				ST_SPEED_WAIT: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_vld_q || result_ch.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Per-item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					now_q   <= sample_ch.now_us;
					edge_q  <= is_edge;
					prod_q  <= SPEED_W'(SPEED_W'(pitch_q) * SPEED_W'(SPEED_SCALE));
					sum_q   <= '0;
					cnt_q   <= '0;
					mean_q  <= NO_INTERVAL;
					speed_q <= '0;
				end
			end
			ST_SUM: begin
				if (rd_vld_q) begin
					sum_q <= sum_q + SUM_W'(ring_rd_data);
				end
				if (ring_cmd.rd_en) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			ST_MEAN_WAIT: begin
				if (div_done) begin
					mean_q <= div_quot[TIME_W-1:0];
				end
			end
			ST_SPEED_WAIT: begin
				if (div_done) begin
					speed_q <= div_quot[SPEED_W-1:0];
				end
			end
			ST_DONE: begin
				if (!out_vld_q || result_ch.ready) begin
					out_speed_q <= speed_q;
					out_mean_q  <= mean_q;
					out_lines_q <= edge_total_q;
					out_edge_q  <= edge_q;
				end
			end
			default: begin
				speed_q <= speed_q;
			end
		endcase
	end

	ppsm_ring #(
		.WINDOW (WINDOW),
		.IDX_W  (IDX_W),
		.CNT_W  (CNT_W)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (ring_cmd),
		.wr_data (interval),
		.rd_addr (cnt_q[IDX_W-1:0]),
		.rd_data (ring_rd_data),
		.fill    (ring_fill)
	);

	ppsm_div #(
		.NUM_W (SUM_W),
		.DEN_W (TIME_W),
		.LEN_W (LEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.len    (div_len),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Channel outputs
	assign sample_ch.ready              = (state_q == ST_IDLE);
	assign result_ch.valid              = out_vld_q;
	assign result_ch.speed_cm_s         = out_speed_q;
	assign result_ch.smoothed_interval_us = out_mean_q;
	assign result_ch.lines_counted      = out_lines_q;
	assign result_ch.edge_recorded      = out_edge_q;

endmodule

`default_nettype wire
